// ===== hdl/lcs_pkg.sv =====
// Package for the longest-common-subsequence block.
// Holds the default sequence length, the fixed field widths and the controller state type.
package lcs_pkg;

	localparam int LCS_MAX_LEN = 32;
	localparam int SYM_W = 8;
	localparam int LEN_W = 6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_ROW,
		ST_CELL_RD,
		ST_CELL_WR,
		ST_TB_RD_UP,
		ST_TB_RD_LEFT,
		ST_TB_DEC,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_CLOSE
	} lcs_state_t;

endpackage

// ===== hdl/lcs_ram.sv =====
// Simple dual-port synchronous RAM: one write port and one registered read port.
// Stand-alone; used for the symbol stores, the length table and the result buffer.
module lcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/lcs_engine.sv =====
// Controller and datapath: loads the sequences, fills the length table, traces back
// and delivers the results. Depends on lcs_pkg; drives the RAMs held by the top level.
module lcs_engine
	import lcs_pkg::*;
#(
	parameter int MAX_LEN = LCS_MAX_LEN,
	parameter int IW = $clog2(MAX_LEN + 1),
	parameter int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	parameter int TAW = $clog2((MAX_LEN + 1) * (MAX_LEN + 1))
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic             seq_end,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SYM_W-1:0] out_symbol,
	output logic             symbol_valid,
	output logic [LEN_W-1:0] common_length,
	output logic             truncated,
	output logic             run_last,
	output logic             a_we,
	output logic [SAW-1:0]   a_waddr,
	output logic             a_re,
	output logic [SAW-1:0]   a_raddr,
	input  logic [SYM_W-1:0] a_rdata,
	output logic             b_we,
	output logic [SAW-1:0]   b_waddr,
	output logic             b_re,
	output logic [SAW-1:0]   b_raddr,
	input  logic [SYM_W-1:0] b_rdata,
	output logic             t_we,
	output logic [TAW-1:0]   t_waddr,
	output logic [IW-1:0]    t_wdata,
	output logic             t_re,
	output logic [TAW-1:0]   t_raddr,
	input  logic [IW-1:0]    t_rdata,
	output logic             s_we,
	output logic [SAW-1:0]   s_waddr,
	output logic [SYM_W-1:0] s_wdata,
	output logic             s_re,
	output logic [SAW-1:0]   s_raddr,
	input  logic [SYM_W-1:0] s_rdata
);

	localparam int DIM = MAX_LEN + 1;

	lcs_state_t state_q, state_d;

	logic [IW-1:0] a_cnt_q, b_cnt_q;
	logic          ovf_q;
	logic [IW-1:0] i_q, j_q, k_q, r_q, len_q;
	logic [IW-1:0] left_q, diag_q, up_q;

	logic             out_valid_q;
	logic [SYM_W-1:0] out_symbol_q;
	logic             symbol_valid_q;
	logic [LEN_W-1:0] common_length_q;
	logic             truncated_q;
	logic             run_last_q;

	logic          accept;
	logic          slot_free;
	logic          load_out;
	logic          match;
	logic          tb_done;
	logic [IW-1:0] cell_up;
	logic [IW-1:0] tb_left;
	logic [IW-1:0] cell_v;

	function automatic logic [TAW-1:0] tbl_addr(input logic [IW-1:0] ii, input logic [IW-1:0] jj);
		tbl_addr = TAW'(ii) * TAW'(DIM) + TAW'(jj);
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = ((state_q == ST_EMIT_OUT) || (state_q == ST_CLOSE)) && slot_free;

	// Row zero and column zero of the table read as zero and are never stored.
	assign match   = (a_rdata == b_rdata);
	assign tb_done = (i_q == '0) || (j_q == '0);
	assign cell_up = (i_q == IW'(1)) ? '0 : t_rdata;
	assign tb_left = (j_q == IW'(1)) ? '0 : t_rdata;
	assign cell_v  = match ? IW'(diag_q + IW'(1)) : ((cell_up >= left_q) ? cell_up : left_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type && seq_end) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if ((a_cnt_q == '0) || (b_cnt_q == '0)) begin
					state_d = ST_CLOSE;
				end else begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				state_d = ST_CELL_RD;
			end
			ST_CELL_RD: begin
				state_d = ST_CELL_WR;
			end
			ST_CELL_WR: begin
				if (j_q == b_cnt_q) begin
					state_d = (i_q == a_cnt_q) ? ST_TB_RD_UP : ST_ROW;
				end else begin
					state_d = ST_CELL_RD;
				end
			end
			ST_TB_RD_UP: begin
				state_d = tb_done ? ST_EMIT_RD : ST_TB_RD_LEFT;
			end
			ST_TB_RD_LEFT: begin
				state_d = ST_TB_DEC;
			end
			ST_TB_DEC: begin
				state_d = ST_TB_RD_UP;
			end
			ST_EMIT_RD: begin
				state_d = (r_q == len_q) ? ST_CLOSE : ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (slot_free) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_CLOSE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		a_we    = accept && !req_type && (a_cnt_q < IW'(MAX_LEN));
		a_waddr = a_cnt_q[SAW-1:0];
		b_we    = accept && req_type && (b_cnt_q < IW'(MAX_LEN));
		b_waddr = b_cnt_q[SAW-1:0];
		a_raddr = SAW'(i_q - IW'(1));
		b_raddr = SAW'(j_q - IW'(1));
		a_re    = 1'b0;
		b_re    = 1'b0;
		t_we    = 1'b0;
		t_waddr = tbl_addr(i_q, j_q);
		t_wdata = cell_v;
		t_re    = 1'b0;
		t_raddr = tbl_addr(IW'(i_q - IW'(1)), j_q);
		s_we    = 1'b0;
		s_waddr = SAW'(k_q - IW'(1));
		s_wdata = a_rdata;
		s_re    = 1'b0;
		s_raddr = r_q[SAW-1:0];
		unique case (state_q) inside
			ST_CELL_RD, ST_TB_RD_UP: begin
				a_re = 1'b1;
				b_re = 1'b1;
				t_re = 1'b1;
			end
			ST_CELL_WR: begin
				t_we = 1'b1;
			end
			ST_TB_RD_LEFT: begin
				t_re    = 1'b1;
				t_raddr = tbl_addr(i_q, IW'(j_q - IW'(1)));
			end
			ST_TB_DEC: begin
				s_we = match;
			end
			ST_EMIT_RD: begin
				s_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			r_q     <= '0;
			len_q   <= '0;
			left_q  <= '0;
			diag_q  <= '0;
			up_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!req_type) begin
							if (a_cnt_q < IW'(MAX_LEN)) begin
								a_cnt_q <= a_cnt_q + IW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							if (b_cnt_q < IW'(MAX_LEN)) begin
								b_cnt_q <= b_cnt_q + IW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				ST_START: begin
					i_q   <= IW'(1);
					len_q <= '0;
					r_q   <= '0;
				end
				ST_ROW: begin
					j_q    <= IW'(1);
					left_q <= '0;
					diag_q <= '0;
				end
				ST_CELL_WR: begin
					left_q <= cell_v;
					diag_q <= cell_up;
					if (j_q == b_cnt_q) begin
						if (i_q == a_cnt_q) begin
							len_q <= cell_v;
							k_q   <= cell_v;
						end else begin
							i_q <= i_q + IW'(1);
						end
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_TB_RD_LEFT: begin
					up_q <= cell_up;
				end
				ST_TB_DEC: begin
					if (match) begin
						k_q <= k_q - IW'(1);
						i_q <= i_q - IW'(1);
						j_q <= j_q - IW'(1);
					end else if (up_q >= tb_left) begin
						i_q <= i_q - IW'(1);
					end else begin
						j_q <= j_q - IW'(1);
					end
				end
				ST_EMIT_OUT: begin
					if (slot_free) begin
						r_q <= r_q + IW'(1);
					end
				end
				ST_CLOSE: begin
					if (slot_free) begin
						a_cnt_q <= '0;
						b_cnt_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			truncated_q <= ovf_q;
			if (state_q == ST_CLOSE) begin
				out_symbol_q    <= '0;
				symbol_valid_q  <= 1'b0;
				common_length_q <= LEN_W'(len_q);
				run_last_q      <= 1'b1;
			end else begin
				out_symbol_q    <= s_rdata;
				symbol_valid_q  <= 1'b1;
				common_length_q <= '0;
				run_last_q      <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_symbol    = out_symbol_q;
	assign symbol_valid  = symbol_valid_q;
	assign common_length = common_length_q;
	assign truncated     = truncated_q;
	assign run_last      = run_last_q;

endmodule

// ===== hdl/lcs_length_and_traceback.sv =====
// Longest-common-subsequence block. Symbols of both sequences are taken one request per
// cycle while idle; the request that ends the second sequence starts a run. A run fills
// the length table cell by cell, traces back over at most n + m steps, and hands out each
// common symbol followed by a closing result with the length. The length table memory has
// a single read port, so a traceback step reads its up and left cells in turn. Sequences
// longer than MAX_LEN are cut and flagged; no new request is taken until the closing
// result has been registered.
module lcs_length_and_traceback
	import lcs_pkg::*;
#(
	parameter int MAX_LEN = LCS_MAX_LEN
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [SYM_W-1:0] symbol,
	input  logic             seq_end,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SYM_W-1:0] out_symbol,
	output logic             symbol_valid,
	output logic [LEN_W-1:0] common_length,
	output logic             truncated,
	output logic             run_last
);

	localparam int IW = $clog2(MAX_LEN + 1);
	localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int TD = (MAX_LEN + 1) * (MAX_LEN + 1);
	localparam int TAW = $clog2(TD);

	logic             a_we, a_re, b_we, b_re, t_we, t_re, s_we, s_re;
	logic [SAW-1:0]   a_waddr, a_raddr, b_waddr, b_raddr, s_waddr, s_raddr;
	logic [SYM_W-1:0] a_rdata, b_rdata, s_wdata, s_rdata;
	logic [TAW-1:0]   t_waddr, t_raddr;
	logic [IW-1:0]    t_wdata, t_rdata;

	lcs_engine #(
		.MAX_LEN(MAX_LEN),
		.IW(IW),
		.SAW(SAW),
		.TAW(TAW)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.seq_end(seq_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_symbol(out_symbol),
		.symbol_valid(symbol_valid),
		.common_length(common_length),
		.truncated(truncated),
		.run_last(run_last),
		.a_we(a_we),
		.a_waddr(a_waddr),
		.a_re(a_re),
		.a_raddr(a_raddr),
		.a_rdata(a_rdata),
		.b_we(b_we),
		.b_waddr(b_waddr),
		.b_re(b_re),
		.b_raddr(b_raddr),
		.b_rdata(b_rdata),
		.t_we(t_we),
		.t_waddr(t_waddr),
		.t_wdata(t_wdata),
		.t_re(t_re),
		.t_raddr(t_raddr),
		.t_rdata(t_rdata),
		.s_we(s_we),
		.s_waddr(s_waddr),
		.s_wdata(s_wdata),
		.s_re(s_re),
		.s_raddr(s_raddr),
		.s_rdata(s_rdata)
	);

	lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(SAW)) u_first_store (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(symbol),
		.re(a_re), .raddr(a_raddr), .rdata(a_rdata)
	);

	lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(SAW)) u_second_store (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(symbol),
		.re(b_re), .raddr(b_raddr), .rdata(b_rdata)
	);

	lcs_ram #(.WIDTH(IW), .DEPTH(TD), .AW(TAW)) u_length_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(t_raddr), .rdata(t_rdata)
	);

	lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(SAW)) u_result_buf (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

endmodule

// ===== tb/sv/tb_lcs_length_and_traceback.sv =====
// Self-checking testbench for lcs_length_and_traceback: directed pairs of sequences, then random
// pairs, with each result checked against a predictor of the common subsequence or, for some
// directed pairs, against a fixed expected result. Depends on lcs_pkg and the block's RTL only.
module tb_lcs_length_and_traceback
	import lcs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit REQ_FIRST = 1'b0;
	localparam bit REQ_SECOND = 1'b1;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_ITEMS = 96;

	typedef struct packed {
		bit req;
		logic [SYM_W-1:0] sym;
		bit last;
	} seq_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic sym_ok;
		logic [LEN_W-1:0] len;
		logic cut;
		logic last;
	} lcs_result_t;

	typedef struct packed {
		bit req;
		logic [SYM_W-1:0] sym;
		bit last;
		bit typed;
		logic [LEN_W-1:0] t_len;
		logic [SYM_W-1:0] t_sym;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic [SYM_W-1:0] symbol = '0;
	logic seq_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SYM_W-1:0] out_symbol;
	logic symbol_valid;
	logic [LEN_W-1:0] common_length;
	logic truncated;
	logic run_last;

	logic [SYM_W-1:0] first_syms [LCS_MAX_LEN];
	logic [SYM_W-1:0] second_syms [LCS_MAX_LEN];
	int first_n = 0;
	int second_n = 0;
	bit cut_flag = 1'b0;
	int lcs_len_tbl [0:LCS_MAX_LEN][0:LCS_MAX_LEN];

	lcs_result_t awaited_lcs_results[$];
	int error_count = 0;
	int results_checked = 0;
	int truncated_runs = 0;
	int pairs_sent = 0;
	int random_items = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	directed_row_t directed_rows [] = '{
		'{REQ_SECOND, 8'h00, 1'b1, 1'b1, 6'd0, 8'h00},
		'{REQ_FIRST, 8'hFF, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'hFF, 1'b1, 1'b1, 6'd1, 8'hFF},
		'{REQ_FIRST, 8'h00, 1'b1, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'hFF, 1'b1, 1'b1, 6'd0, 8'h00},
		'{REQ_FIRST, 8'h12, 1'b1, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'h34, 1'b1, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'h34, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'h12, 1'b1, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'h55, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'hAA, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'h0F, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'hAA, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'hF0, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'hF0, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'h55, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'h80, 1'b1, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'h07, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'h07, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_FIRST, 8'h07, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'h07, 1'b0, 1'b0, 6'd0, 8'h00},
		'{REQ_SECOND, 8'h07, 1'b1, 1'b0, 6'd0, 8'h00}
	};

	lcs_length_and_traceback dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.symbol(symbol),
		.seq_end(seq_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_symbol(out_symbol),
		.symbol_valid(symbol_valid),
		.common_length(common_length),
		.truncated(truncated),
		.run_last(run_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic seq_item_t make_item(bit req, logic [SYM_W-1:0] sym, bit last);
		seq_item_t it;
		it.req = req;
		it.sym = sym;
		it.last = last;
		return it;
	endfunction

	function automatic lcs_result_t make_result(logic [SYM_W-1:0] sym, logic sym_ok,
			logic [LEN_W-1:0] len, logic cut, logic last);
		lcs_result_t r;
		r.sym = sym;
		r.sym_ok = sym_ok;
		r.len = len;
		r.cut = cut;
		r.last = last;
		return r;
	endfunction

	// Appends a symbol to its sequence; the end of the second sequence fills the length
	// table, traces back and returns the common symbols followed by the closing result.
	task automatic lcs_accept(input seq_item_t it, ref lcs_result_t results[$]);
		int len;
		int k;
		int i;
		int j;
		logic [SYM_W-1:0] common [LCS_MAX_LEN];
		results.delete();
		if (it.req == REQ_FIRST) begin
			if (first_n < LCS_MAX_LEN) begin
				first_syms[first_n] = it.sym;
				first_n++;
			end else begin
				cut_flag = 1'b1;
			end
			return;
		end
		if (second_n < LCS_MAX_LEN) begin
			second_syms[second_n] = it.sym;
			second_n++;
		end else begin
			cut_flag = 1'b1;
		end
		if (!it.last)
			return;
		for (i = 0; i <= first_n; i++)
			lcs_len_tbl[i][0] = 0;
		for (j = 0; j <= second_n; j++)
			lcs_len_tbl[0][j] = 0;
		for (i = 1; i <= first_n; i++) begin
			for (j = 1; j <= second_n; j++) begin
				if (first_syms[i-1] == second_syms[j-1])
					lcs_len_tbl[i][j] = lcs_len_tbl[i-1][j-1] + 1;
				else if (lcs_len_tbl[i-1][j] >= lcs_len_tbl[i][j-1])
					lcs_len_tbl[i][j] = lcs_len_tbl[i-1][j];
				else
					lcs_len_tbl[i][j] = lcs_len_tbl[i][j-1];
			end
		end
		len = lcs_len_tbl[first_n][second_n];
		k = len;
		i = first_n;
		j = second_n;
		while (i != 0 && j != 0) begin
			if (first_syms[i-1] == second_syms[j-1]) begin
				if (k > 0) begin
					k--;
					common[k] = first_syms[i-1];
				end
				i--;
				j--;
			end else if (lcs_len_tbl[i-1][j] >= lcs_len_tbl[i][j-1]) begin
				i--;
			end else begin
				j--;
			end
		end
		for (k = 0; k < len; k++)
			results.push_back(make_result(common[k], 1'b1, '0, cut_flag, 1'b0));
		results.push_back(make_result('0, 1'b0, LEN_W'(len), cut_flag, 1'b1));
		first_n = 0;
		second_n = 0;
		cut_flag = 1'b0;
	endtask

	task automatic offer_request(input seq_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.req;
		symbol <= it.sym;
		seq_end <= it.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_and_predict(input seq_item_t it);
		lcs_result_t outs[$];
		offer_request(it);
		lcs_accept(it, outs);
		foreach (outs[r])
			awaited_lcs_results.push_back(outs[r]);
		random_items++;
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] base, bit wide);
		if (wide)
			return SYM_W'($urandom);
		return base + SYM_W'($urandom_range(2));
	endfunction

	// One pair of sequences, optionally interleaved, optionally with the second copying the
	// first where their positions overlap; the request that ends the second sequence always goes last.
	task automatic run_pair(input int n, input int m, input bit mixed, input bit mirror);
		seq_item_t firsts[$];
		seq_item_t seconds[$];
		seq_item_t tail;
		logic [SYM_W-1:0] base;
		bit wide;
		base = SYM_W'($urandom);
		wide = ($urandom_range(3) == 0);
		for (int k = 0; k < n; k++)
			firsts.push_back(make_item(REQ_FIRST, pick_symbol(base, wide),
				$urandom_range(7) == 0));
		for (int k = 0; k < m; k++)
			seconds.push_back(make_item(REQ_SECOND,
				(mirror && k < n) ? firsts[k].sym : pick_symbol(base, wide), 1'b0));
		tail = seconds.pop_back();
		tail.last = 1'b1;
		while (firsts.size() != 0 || seconds.size() != 0) begin
			if (seconds.size() == 0 || (firsts.size() != 0 && (!mixed || $urandom_range(1))))
				send_and_predict(firsts.pop_front());
			else
				send_and_predict(seconds.pop_front());
		end
		send_and_predict(tail);
		pairs_sent++;
	endtask

	task automatic report_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
				act_val);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_lcs_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %0h/%0b/%0d/%0b/%0b",
					$time, out_symbol, symbol_valid, common_length, truncated, run_last);
				error_count++;
			end else begin
				lcs_result_t e;
				e = awaited_lcs_results.pop_front();
				report_field("out_symbol", e.sym, out_symbol);
				report_field("symbol_valid", e.sym_ok, symbol_valid);
				report_field("common_length", e.len, common_length);
				report_field("truncated", e.cut, truncated);
				report_field("run_last", e.last, run_last);
				results_checked++;
				if (e.last && e.cut)
					truncated_runs++;
			end
		end
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still awaited.", awaited_lcs_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		lcs_result_t outs[$];
		seq_item_t it;
		int run_idx;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[d]) begin
			it = make_item(directed_rows[d].req, directed_rows[d].sym, directed_rows[d].last);
			offer_request(it);
			lcs_accept(it, outs);
			if (directed_rows[d].typed) begin
				for (int r = 0; r < directed_rows[d].t_len; r++)
					awaited_lcs_results.push_back(make_result(directed_rows[d].t_sym, 1'b1, '0,
						1'b0, 1'b0));
				awaited_lcs_results.push_back(make_result('0, 1'b0, directed_rows[d].t_len,
					1'b0, 1'b1));
			end else begin
				foreach (outs[r])
					awaited_lcs_results.push_back(outs[r]);
			end
			if (it.req == REQ_SECOND && it.last)
				pairs_sent++;
		end
		in_valid <= 1'b0;
		while (awaited_lcs_results.size() != 0)
			@(posedge clk);

		run_idx = 0;
		while (random_items < RANDOM_ITEMS || run_idx < 10) begin
			case ((run_idx / 3) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 72;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 72;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			if (run_idx == 6)
				hold_request = 1'b1;
			if (run_idx == 3)
				run_pair(LCS_MAX_LEN + 1, LCS_MAX_LEN + 1, 1'b0, 1'b1);
			else if (run_idx == 9)
				run_pair(0, $urandom_range(1, 4), 1'b0, 1'b0);
			else
				run_pair($urandom_range(0, 4), $urandom_range(1, 4), $urandom_range(3) == 0,
					$urandom_range(4) == 0);
			if (run_idx % 5 == 4) begin
				in_valid <= 1'b0;
				while (awaited_lcs_results.size() != 0)
					@(posedge clk);
			end
			run_idx++;
		end
		in_valid <= 1'b0;

		while (awaited_lcs_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d sequence pairs and %0d checked results, %0d of them in cut runs,",
			pairs_sent, results_checked, truncated_runs);
		$display("under idle sender, stalled receiver and a long output hold-off.");
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
